[design/jsu_pkg.sv]
// Shared types, codes and helper functions for the JSON string unescape unit.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int CountWidth = 21;

    // Decoder phases
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_STR        = 4'd1;
    localparam logic [3:0] PH_ESC        = 4'd2;
    localparam logic [3:0] PH_HEX        = 4'd3;
    localparam logic [3:0] PH_AFTER_HIGH = 4'd4;
    localparam logic [3:0] PH_HIGH_BS    = 4'd5;
    localparam logic [3:0] PH_LOW_HEX    = 4'd6;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NO_QUOTE    = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG    = 2'd1;
    localparam logic [1:0] ERR_UNTERM      = 2'd2;
    localparam logic [1:0] ERR_TRUNC_ESC   = 2'd3;

    localparam logic [CountWidth-1:0] MAX_LENGTH_RESET = 21'd65536;
    localparam logic [CountWidth-1:0] COUNT_SAT        = 21'h1FFFFF;

    typedef struct packed {
        logic [3:0]            phase;
        logic [15:0]           code_accum;
        logic [15:0]           high_half;
        logic [1:0]            hex_count;
        logic [CountWidth-1:0] out_count;
    } jsu_state_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
    } jsu_result_t;

    // Up to four results caused by one input word
    typedef struct packed {
        logic [2:0]             count;
        jsu_result_t [3:0]      slot;
    } jsu_burst_t;

    typedef struct packed {
        logic [2:0]      count;
        logic [3:0][7:0] bytes;
    } jsu_utf8_t;

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            v = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            v = 4'(b - 8'h37);
        end
        return v;
    endfunction

    function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
        jsu_utf8_t r;
        r.bytes = '0;
        if (cp <= 21'h7F)
        begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end
        else if (cp <= 21'h7FF)
        begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp <= 21'hFFFF)
        begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic logic [CountWidth-1:0] sat_add(input logic [CountWidth-1:0] a,
                                                      input logic [2:0] inc);
        logic [CountWidth:0] s;
        s = {1'b0, a} + {{(CountWidth-2){1'b0}}, inc};
        return s[CountWidth] ? COUNT_SAT : s[CountWidth-1:0];
    endfunction

endpackage

[design/jsu_ifs.sv]
// Valid/ready channel interfaces for the JSON string unescape unit.
// Depends on nothing; compiled after jsu_pkg.
`timescale 1ns / 1ps

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       source_end;

    modport source (output valid, output in_byte, output source_end, input ready);
    modport sink   (input valid, input in_byte, input source_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

[design/jsu_decode.sv]
// Next-state and result logic for one source byte of the unescape unit.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_decode
(
    input  jsu_pkg::jsu_state_t         state,
    input  logic [jsu_pkg::CountWidth-1:0] max_length,
    input  logic [7:0]                  in_byte,
    input  logic                        source_end,
    output jsu_pkg::jsu_state_t         state_next,
    output jsu_pkg::jsu_burst_t         burst
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] c;
        case (b)
            8'h62:   c = 8'h08;
            8'h66:   c = 8'h0C;
            8'h6E:   c = 8'h0A;
            8'h72:   c = 8'h0D;
            8'h74:   c = 8'h09;
            default: c = b;
        endcase
        return c;
    endfunction

    logic [15:0]           acc_new;
    logic                  hex_done;
    logic                  acc_high;
    logic                  acc_low;
    logic                  enc_en;
    logic [20:0]           enc_cp;
    jsu_utf8_t             enc;
    logic [2:0]            n_enc;
    logic [CountWidth-1:0] cnt_mid;
    logic                  too_long;
    logic                  ext_v;
    logic                  ext_data;
    jsu_result_t           ext_res;
    jsu_state_t            nxt;

    always_comb
    begin
        acc_new  = {state.code_accum[11:0], hex_value(in_byte)};
        hex_done = (state.hex_count == 2'd3);
        acc_high = (acc_new >= 16'hD800) && (acc_new <= 16'hDBFF);
        acc_low  = (acc_new >= 16'hDC00) && (acc_new <= 16'hDFFF);

        // Pick the code point, if any, that goes out ahead of everything else
        enc_en = 1'b0;
        enc_cp = '0;
        case (state.phase)
            PH_HEX:
            begin
                if (!source_end && hex_done && !acc_high)
                begin
                    enc_en = 1'b1;
                    enc_cp = {5'd0, acc_new};
                end
            end
            PH_AFTER_HIGH:
            begin
                if (source_end || in_byte != CH_BSL)
                begin
                    enc_en = 1'b1;
                    enc_cp = {5'd0, state.high_half};
                end
            end
            PH_HIGH_BS:
            begin
                if (source_end || in_byte != CH_U)
                begin
                    enc_en = 1'b1;
                    enc_cp = {5'd0, state.high_half};
                end
            end
            PH_LOW_HEX:
            begin
                if (source_end || hex_done)
                begin
                    enc_en = 1'b1;
                    if (!source_end && acc_low)
                    begin
                        enc_cp = 21'h10000 + {1'b0, state.high_half[9:0], acc_new[9:0]};
                    end
                    else
                    begin
                        enc_cp = {5'd0, state.high_half};
                    end
                end
            end
            default:
            begin
                enc_en = 1'b0;
            end
        endcase

        enc      = utf8_encode(enc_cp);
        n_enc    = enc_en ? enc.count : 3'd0;
        cnt_mid  = sat_add(state.out_count, n_enc);
        too_long = (cnt_mid >= max_length);

        // Trailing result and phase update
        nxt                = state;
        nxt.out_count      = cnt_mid;
        ext_v              = 1'b0;
        ext_data           = 1'b0;
        ext_res            = '0;
        ext_res.kind       = KIND_ERROR;
        if (enc_en)
        begin
            nxt.phase = PH_STR;
        end

        case (state.phase)
            PH_STR, PH_AFTER_HIGH:
            begin
                if (state.phase == PH_AFTER_HIGH && !source_end && in_byte == CH_BSL)
                begin
                    nxt.phase = PH_HIGH_BS;
                end
                else if (source_end)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = ERR_UNTERM;
                    nxt.phase          = PH_IDLE;
                end
                else if (too_long)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = ERR_TOO_LONG;
                    nxt.phase          = PH_IDLE;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    ext_v        = 1'b1;
                    ext_res.kind = KIND_DONE;
                    nxt.phase    = PH_IDLE;
                end
                else if (in_byte == CH_BSL)
                begin
                    nxt.phase = PH_ESC;
                end
                else
                begin
                    ext_v            = 1'b1;
                    ext_data         = 1'b1;
                    ext_res.kind     = KIND_DATA;
                    ext_res.out_byte = in_byte;
                end
            end
            PH_ESC, PH_HIGH_BS:
            begin
                if (state.phase == PH_HIGH_BS && too_long && enc_en)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = ERR_TOO_LONG;
                    nxt.phase          = PH_IDLE;
                end
                else if (source_end)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = ERR_TRUNC_ESC;
                    nxt.phase          = PH_IDLE;
                end
                else if (in_byte == CH_U)
                begin
                    nxt.phase      = (state.phase == PH_ESC) ? PH_HEX : PH_LOW_HEX;
                    nxt.code_accum = '0;
                    nxt.hex_count  = '0;
                end
                else
                begin
                    ext_v            = 1'b1;
                    ext_data         = 1'b1;
                    ext_res.kind     = KIND_DATA;
                    ext_res.out_byte = esc_map(in_byte);
                    nxt.phase        = PH_STR;
                end
            end
            PH_HEX, PH_LOW_HEX:
            begin
                if (source_end)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = (state.phase == PH_LOW_HEX && too_long)
                                         ? ERR_TOO_LONG : ERR_TRUNC_ESC;
                    nxt.phase          = PH_IDLE;
                end
                else
                begin
                    nxt.code_accum = acc_new;
                    if (!hex_done)
                    begin
                        nxt.hex_count = state.hex_count + 2'd1;
                    end
                    else if (state.phase == PH_HEX && acc_high)
                    begin
                        nxt.high_half = acc_new;
                        nxt.phase     = PH_AFTER_HIGH;
                    end
                end
            end
            default:
            begin
                if (source_end || in_byte != CH_QUOTE)
                begin
                    ext_v              = 1'b1;
                    ext_res.error_code = ERR_NO_QUOTE;
                end
                else
                begin
                    nxt.phase     = PH_STR;
                    nxt.out_count = '0;
                end
            end
        endcase

        if (ext_data)
        begin
            nxt.out_count = sat_add(cnt_mid, 3'd1);
        end

        state_next  = nxt;
        burst.count = n_enc + {2'd0, ext_v};
        for (int i = 0; i < 4; i++)
        begin
            if (3'(i) < n_enc)
            begin
                burst.slot[i].out_byte   = enc.bytes[i];
                burst.slot[i].kind       = KIND_DATA;
                burst.slot[i].error_code = ERR_NO_QUOTE;
            end
            else
            begin
                burst.slot[i] = ext_res;
            end
        end
    end

endmodule

[design/json_string_unescape_utf8_unit.sv]
// JSON string unescape unit: quoted source bytes in, decoded UTF-8 bytes out.
// The first result of a word is offered in the cycle after the word is taken.
// Throughput: one source word per cycle while each word gives at most one result and
// the output is ready; a word giving several results (up to four) holds the input
// until the single output port drains the result register, one entry per ready cycle.
// Reset: decoder idle awaiting an opening quote, max_length 65536, no results held.
`timescale 1ns / 1ps

module json_string_unescape_utf8_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [jsu_pkg::CountWidth-1:0] cfg_wdata,
    jsu_in_if.sink                         src,
    jsu_out_if.source                      dst
);
    import jsu_pkg::*;

    jsu_state_t            state_reg;
    jsu_state_t            state_next;
    logic [CountWidth-1:0] max_length_reg;
    jsu_result_t [3:0]     slot_reg;
    jsu_result_t [3:0]     slot_next;
    logic [2:0]            count_reg;
    logic [2:0]            count_next;
    jsu_burst_t            burst;
    logic                  in_take;
    logic                  out_take;

    jsu_decode u_decode
    (
        .state      (state_reg),
        .max_length (max_length_reg),
        .in_byte    (src.in_byte),
        .source_end (src.source_end),
        .state_next (state_next),
        .burst      (burst)
    );

    // Take a new word once the held results are gone or the final one leaves now
    assign src.ready = (count_reg == 3'd0) || (count_reg == 3'd1 && dst.ready);
    assign in_take   = src.valid && src.ready;
    assign out_take  = dst.valid && dst.ready;

    assign dst.valid      = (count_reg != 3'd0);
    assign dst.out_byte   = slot_reg[0].out_byte;
    assign dst.kind       = slot_reg[0].kind;
    assign dst.error_code = slot_reg[0].error_code;
    assign dst.last       = (count_reg == 3'd1);

    always_comb
    begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (in_take)
        begin
            slot_next  = burst.slot;
            count_next = burst.count;
        end
        else if (out_take)
        begin
            // advance the queue by one entry
            slot_next  = {slot_reg[3], slot_reg[3:1]};
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{phase: PH_IDLE, code_accum: '0, high_half: '0,
                                hex_count: '0, out_count: '0};
            count_reg      <= '0;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else
        begin
            if (in_take)
            begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
            if (cfg_we)
            begin
                max_length_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule
